// ----- hdl/assert_macros.svh -----
// Assertion helpers shared by the RTL. Both expect clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property, checked outside reset.
`define SI_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same-cycle implication, checked outside reset.
`define SI_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ----- hdl/segi2d_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package segi2d_pkg;

  // Default coordinate width (signed Q8.8 at 16 bits).
  localparam int unsigned SI_COORD_WIDTH = 16;

endpackage

`default_nettype wire

// ----- hdl/segment_intersection_2d.sv -----
// Segment/edge intersection test in 2D. A transaction is taken whenever start is high and
// busy is low; busy is only high while rst_n is held low, so one test may be issued every
// clock. Each test gives exactly one result, shown on the out_ ports for a single cycle
// with out_valid high, in issue order. The result cannot be held off, so the receiver must
// take it in that cycle. The pipeline is built around the restoring divider for the contact
// point, one quotient bit per stage (COORD_WIDTH + 1 stages), behind seven stages of
// differences, cross products, sign/magnitude split, the two-part product and the overflow
// check, and followed by one output stage that applies the sign, adds the start point and
// saturates, or clears the contact point of a parallel result.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module segment_intersection_2d import segi2d_pkg::*; #(
  parameter int unsigned COORD_WIDTH = SI_COORD_WIDTH
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic signed [COORD_WIDTH-1:0] in_start_x,
  input  wire logic signed [COORD_WIDTH-1:0] in_start_y,
  input  wire logic signed [COORD_WIDTH-1:0] in_move_x,
  input  wire logic signed [COORD_WIDTH-1:0] in_move_y,
  input  wire logic signed [COORD_WIDTH-1:0] in_edge_a_x,
  input  wire logic signed [COORD_WIDTH-1:0] in_edge_a_y,
  input  wire logic signed [COORD_WIDTH-1:0] in_edge_b_x,
  input  wire logic signed [COORD_WIDTH-1:0] in_edge_b_y,
  output logic                               out_valid,
  output logic                               out_hit,
  output logic                               out_parallel,
  output logic signed [COORD_WIDTH-1:0]      out_contact_x,
  output logic signed [COORD_WIDTH-1:0]      out_contact_y
);

  localparam int unsigned W   = COORD_WIDTH;
  localparam int unsigned DW  = W + 1;          // coordinate differences
  localparam int unsigned PW  = 2 * DW;         // cross product terms
  localparam int unsigned NW  = PW + 1;         // den, na, nb
  localparam int unsigned MW  = 2 * W + 1;      // |na|, |den|
  localparam int unsigned HL  = W + 1;          // low slice of |na|
  localparam int unsigned QW  = MW + W;         // |na * m|
  localparam int unsigned LAT = W + 9;

  localparam logic signed [W+2:0] VHI = $signed({4'b0000, {(W-1){1'b1}}});
  localparam logic signed [W+2:0] VLO = $signed({4'b1111, {(W-1){1'b0}}});
  localparam logic [W-1:0]        CMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0]        CMIN = {1'b1, {(W-1){1'b0}}};

  typedef struct packed {
    logic                hit;
    logic                par;
    logic signed [W-1:0] sx;
    logic signed [W-1:0] sy;
    logic                neg_x;
    logic                neg_y;
    logic                ovf_x;
    logic                ovf_y;
    logic [QW-1:0]       rx;
    logic [QW-1:0]       ry;
    logic [W:0]          qx;
    logic [W:0]          qy;
    logic [MW-1:0]       d;
  } div_t;

  function automatic logic in_unit(input logic signed [NW-1:0] num,
                                   input logic signed [NW-1:0] den);
    if (den[NW-1]) begin
      return (num <= 0) && (num >= den);
    end
    return (num >= 0) && (num <= den);
  endfunction

  function automatic logic [W-1:0] sat(input logic signed [W+2:0] v, input logic ovf,
                                       input logic neg);
    priority if (ovf) begin
      return neg ? CMIN : CMAX;
    end else if (v > VHI) begin
      return CMAX;
    end else if (v < VLO) begin
      return CMIN;
    end else begin
      return v[W-1:0];
    end
  endfunction

  logic in_acc;
  assign busy   = ~rst_n;
  assign in_acc = start & ~busy;

  // Stage 1: edge vector and start offset
  logic                 s1_vld_r;
  logic signed [W-1:0]  s1_sx_r, s1_sy_r, s1_mx_r, s1_my_r;
  logic signed [DW-1:0] s1_ex_r, s1_ey_r, s1_dx_r, s1_dy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= in_acc;
    end
    s1_sx_r <= in_start_x;
    s1_sy_r <= in_start_y;
    s1_mx_r <= in_move_x;
    s1_my_r <= in_move_y;
    s1_ex_r <= $signed({in_edge_b_x[W-1], in_edge_b_x}) - $signed({in_edge_a_x[W-1], in_edge_a_x});
    s1_ey_r <= $signed({in_edge_b_y[W-1], in_edge_b_y}) - $signed({in_edge_a_y[W-1], in_edge_a_y});
    s1_dx_r <= $signed({in_start_x[W-1], in_start_x}) - $signed({in_edge_a_x[W-1], in_edge_a_x});
    s1_dy_r <= $signed({in_start_y[W-1], in_start_y}) - $signed({in_edge_a_y[W-1], in_edge_a_y});
  end

  // Stage 2: the six cross product terms
  logic                 s2_vld_r;
  logic signed [W-1:0]  s2_sx_r, s2_sy_r, s2_mx_r, s2_my_r;
  logic signed [PW-1:0] s2_eymx_r, s2_exmy_r, s2_exdy_r, s2_eydx_r, s2_mxdy_r, s2_mydx_r;
  logic signed [DW-1:0] s1_mxe, s1_mye;

  assign s1_mxe = $signed({s1_mx_r[W-1], s1_mx_r});
  assign s1_mye = $signed({s1_my_r[W-1], s1_my_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else begin
      s2_vld_r <= s1_vld_r;
    end
    s2_sx_r   <= s1_sx_r;
    s2_sy_r   <= s1_sy_r;
    s2_mx_r   <= s1_mx_r;
    s2_my_r   <= s1_my_r;
    s2_eymx_r <= s1_ey_r * s1_mxe;
    s2_exmy_r <= s1_ex_r * s1_mye;
    s2_exdy_r <= s1_ex_r * s1_dy_r;
    s2_eydx_r <= s1_ey_r * s1_dx_r;
    s2_mxdy_r <= s1_mxe * s1_dy_r;
    s2_mydx_r <= s1_mye * s1_dx_r;
  end

  // Stage 3: denominator and numerators
  logic                 s3_vld_r;
  logic signed [W-1:0]  s3_sx_r, s3_sy_r, s3_mx_r, s3_my_r;
  logic signed [NW-1:0] s3_den_r, s3_na_r, s3_nb_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_vld_r <= 1'b0;
    end else begin
      s3_vld_r <= s2_vld_r;
    end
    s3_sx_r  <= s2_sx_r;
    s3_sy_r  <= s2_sy_r;
    s3_mx_r  <= s2_mx_r;
    s3_my_r  <= s2_my_r;
    s3_den_r <= $signed({s2_eymx_r[PW-1], s2_eymx_r}) - $signed({s2_exmy_r[PW-1], s2_exmy_r});
    s3_na_r  <= $signed({s2_exdy_r[PW-1], s2_exdy_r}) - $signed({s2_eydx_r[PW-1], s2_eydx_r});
    s3_nb_r  <= $signed({s2_mxdy_r[PW-1], s2_mxdy_r}) - $signed({s2_mydx_r[PW-1], s2_mydx_r});
  end

  // Stage 4: hit decision, signs and magnitudes
  logic                s4_vld_r, s4_hit_r, s4_par_r, s4_negx_r, s4_negy_r;
  logic signed [W-1:0] s4_sx_r, s4_sy_r;
  logic [MW-1:0]       s4_nam_r, s4_dm_r;
  logic [W-1:0]        s4_mxm_r, s4_mym_r;
  logic [NW-1:0]       na_abs, den_abs;
  logic                par_nxt;

  assign na_abs  = s3_na_r[NW-1]  ? (~s3_na_r + 1'b1)  : s3_na_r;
  assign den_abs = s3_den_r[NW-1] ? (~s3_den_r + 1'b1) : s3_den_r;
  assign par_nxt = (s3_den_r == '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_vld_r <= 1'b0;
    end else begin
      s4_vld_r <= s3_vld_r;
    end
    s4_par_r  <= par_nxt;
    // a zero denominator would pass the range test when na is zero
    s4_hit_r  <= !par_nxt && in_unit(s3_na_r, s3_den_r) && in_unit(s3_nb_r, s3_den_r);
    s4_sx_r   <= s3_sx_r;
    s4_sy_r   <= s3_sy_r;
    s4_negx_r <= s3_na_r[NW-1] ^ s3_mx_r[W-1] ^ s3_den_r[NW-1];
    s4_negy_r <= s3_na_r[NW-1] ^ s3_my_r[W-1] ^ s3_den_r[NW-1];
    s4_nam_r  <= na_abs[MW-1:0];
    s4_dm_r   <= den_abs[MW-1:0];
    s4_mxm_r  <= s3_mx_r[W-1] ? (~s3_mx_r + 1'b1) : s3_mx_r;
    s4_mym_r  <= s3_my_r[W-1] ? (~s3_my_r + 1'b1) : s3_my_r;
  end

  // Stage 5: |na| * |m| as two partial products
  logic                s5_vld_r, s5_hit_r, s5_par_r, s5_negx_r, s5_negy_r;
  logic signed [W-1:0] s5_sx_r, s5_sy_r;
  logic [HL+W-1:0]     s5_lox_r, s5_loy_r;
  logic [2*W-1:0]      s5_hix_r, s5_hiy_r;
  logic [MW-1:0]       s5_dm_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s5_vld_r <= 1'b0;
    end else begin
      s5_vld_r <= s4_vld_r;
    end
    s5_hit_r  <= s4_hit_r;
    s5_par_r  <= s4_par_r;
    s5_negx_r <= s4_negx_r;
    s5_negy_r <= s4_negy_r;
    s5_sx_r   <= s4_sx_r;
    s5_sy_r   <= s4_sy_r;
    s5_dm_r   <= s4_dm_r;
    s5_lox_r  <= s4_nam_r[HL-1:0] * s4_mxm_r;
    s5_loy_r  <= s4_nam_r[HL-1:0] * s4_mym_r;
    s5_hix_r  <= s4_nam_r[MW-1:HL] * s4_mxm_r;
    s5_hiy_r  <= s4_nam_r[MW-1:HL] * s4_mym_r;
  end

  // Stage 6: sum the partial products
  logic                s6_vld_r, s6_hit_r, s6_par_r, s6_negx_r, s6_negy_r;
  logic signed [W-1:0] s6_sx_r, s6_sy_r;
  logic [QW-1:0]       s6_nx_r, s6_ny_r;
  logic [MW-1:0]       s6_dm_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s6_vld_r <= 1'b0;
    end else begin
      s6_vld_r <= s5_vld_r;
    end
    s6_hit_r  <= s5_hit_r;
    s6_par_r  <= s5_par_r;
    s6_negx_r <= s5_negx_r;
    s6_negy_r <= s5_negy_r;
    s6_sx_r   <= s5_sx_r;
    s6_sy_r   <= s5_sy_r;
    s6_dm_r   <= s5_dm_r;
    s6_nx_r   <= {s5_hix_r, {HL{1'b0}}} + QW'(s5_lox_r);
    s6_ny_r   <= {s5_hiy_r, {HL{1'b0}}} + QW'(s5_loy_r);
  end

  // Divider: stage 0 flags quotients of 2^(W+1) or more, which saturate whatever
  // the start point; the rest resolve one quotient bit each, MSB first.
  logic dvld_r [0:W+1];
  div_t div_r  [0:W+1];
  div_t dv0_nxt;

  always_comb begin
    dv0_nxt       = '0;
    dv0_nxt.hit   = s6_hit_r;
    dv0_nxt.par   = s6_par_r;
    dv0_nxt.sx    = s6_sx_r;
    dv0_nxt.sy    = s6_sy_r;
    dv0_nxt.neg_x = s6_negx_r;
    dv0_nxt.neg_y = s6_negy_r;
    dv0_nxt.ovf_x = {1'b0, s6_nx_r} >= {s6_dm_r, {(W+1){1'b0}}};
    dv0_nxt.ovf_y = {1'b0, s6_ny_r} >= {s6_dm_r, {(W+1){1'b0}}};
    dv0_nxt.rx    = s6_nx_r;
    dv0_nxt.ry    = s6_ny_r;
    dv0_nxt.d     = s6_dm_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dvld_r[0] <= 1'b0;
    end else begin
      dvld_r[0] <= s6_vld_r;
    end
    div_r[0] <= dv0_nxt;
  end

  for (genvar j = 0; j <= W; j++) begin : g_div
    localparam int unsigned K = W - j;
    div_t          dv_nxt;
    logic [QW-1:0] tr_x, tr_y;

    assign tr_x = QW'(div_r[j].d) << K;
    assign tr_y = QW'(div_r[j].d) << K;

    always_comb begin
      dv_nxt = div_r[j];
      if (div_r[j].rx >= tr_x) begin
        dv_nxt.rx    = div_r[j].rx - tr_x;
        dv_nxt.qx[K] = 1'b1;
      end
      if (div_r[j].ry >= tr_y) begin
        dv_nxt.ry    = div_r[j].ry - tr_y;
        dv_nxt.qy[K] = 1'b1;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dvld_r[j+1] <= 1'b0;
      end else begin
        dvld_r[j+1] <= dvld_r[j];
      end
      div_r[j+1] <= dv_nxt;
    end
  end

  // Output stage: apply sign, add start point, saturate; parallel results are zeroed
  div_t                dl;
  logic signed [W+2:0] qs_x, qs_y, v_x, v_y;
  logic [W-1:0]        cx_nxt, cy_nxt;
  logic                out_valid_r, out_hit_r, out_par_r;
  logic signed [W-1:0] out_cx_r, out_cy_r;

  assign dl   = div_r[W+1];
  assign qs_x = dl.neg_x ? -$signed({2'b00, dl.qx}) : $signed({2'b00, dl.qx});
  assign qs_y = dl.neg_y ? -$signed({2'b00, dl.qy}) : $signed({2'b00, dl.qy});
  assign v_x  = $signed({{3{dl.sx[W-1]}}, dl.sx}) + qs_x;
  assign v_y  = $signed({{3{dl.sy[W-1]}}, dl.sy}) + qs_y;
  assign cx_nxt = dl.par ? '0 : sat(v_x, dl.ovf_x, dl.neg_x);
  assign cy_nxt = dl.par ? '0 : sat(v_y, dl.ovf_y, dl.neg_y);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= dvld_r[W+1];
    end
    out_hit_r <= dl.hit;
    out_par_r <= dl.par;
    out_cx_r  <= cx_nxt;
    out_cy_r  <= cy_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_hit       = out_hit_r;
  assign out_parallel  = out_par_r;
  assign out_contact_x = out_cx_r;
  assign out_contact_y = out_cy_r;

  logic [QW-1:0] d_ext;
  assign d_ext = QW'(dl.d);

  `SI_ASSERT_IMPL(a_issue_to_result, in_acc, ##LAT out_valid, "result strobe missing")
  `SI_ASSERT_IMPL(a_result_from_issue, out_valid, $past(in_acc, LAT), "result without issue")
  `SI_ASSERT_IMPL(a_div_rem, dvld_r[W+1] && !dl.ovf_x && !dl.par, dl.rx < d_ext, "divider remainder not below divisor")
  `SI_ASSERT_IMPL(a_parallel, out_valid && out_parallel, !out_hit && out_contact_x == '0 && out_contact_y == '0, "parallel result not cleared")

endmodule

`default_nettype wire
